// File: rtl/affine_gap_global_alignment_score_defines.svh
// assertion macros used by the port level checker
// no dependencies
`ifndef AFFINE_GAP_GLOBAL_ALIGNMENT_SCORE_DEFINES_SVH
`define AFFINE_GAP_GLOBAL_ALIGNMENT_SCORE_DEFINES_SVH

// property checked only outside reset
`define AGAS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("agas assertion failed");

// property checked at every edge, reset included
`define AGAS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("agas assertion failed");

`endif

// File: rtl/agas_pkg.sv
// package for the affine gap global alignment block
// constants, input actions, register indexes and the sequencer state type; no dependencies
package agas_pkg;

    localparam int AGAS_MAX_LEN     = 4096;
    localparam int AGAS_SYMBOL_BITS = 8;
    localparam int AGAS_SCORE_W     = 24;

    // input actions
    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_RUN    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_OPEN     = 2'd2;
    localparam logic [1:0] REG_EXTEND   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_EDGE,
        S_ROW,
        S_CELL,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

// File: rtl/agas_if.sv
// stream interfaces for the input and the result channel
// depends on agas_pkg for the score width
interface agas_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;
    modport source (output valid, output action, output symbol, input ready);
    modport sink (input valid, input action, input symbol, output ready);
endinterface

interface agas_out_if import agas_pkg::*; ;
    logic                           valid;
    logic                           ready;
    logic signed [AGAS_SCORE_W-1:0] score;
    logic                           dropped;
    modport source (output valid, output score, output dropped, input ready);
    modport sink (input valid, input score, input dropped, output ready);
endinterface

// File: rtl/agas_ram.sv
// simple dual port synchronous ram, one write and one registered read port
// no dependencies
module agas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// File: rtl/affine_gap_global_alignment_score.sv
// Affine gap global alignment score, three state recurrence over two rows.
// Input channel i_in: action 0 appends symbol to the first sequence, 1 to
// the second, 2 runs the alignment, 3 is ignored. Loads are accepted back
// to back while idle; a symbol past the capacity is dropped and flagged.
// A run returns one word on o_out: score (24 bit signed, saturated) and
// dropped. The cell walk handles one cell per cycle through the two row
// memories, with a row start step before each row that fetches the symbol
// of the first sequence. With an empty sequence the walk is skipped and
// the score comes from the edge step. Loads and runs are taken only while
// the sequencer is idle; a finished word sits in the output register, so
// loads keep flowing while the receiver stalls, and a following run holds
// its word until the previous one is taken. Reset clears lengths, flag,
// output and restores the default scores; memories are not cleared. The
// configuration port writes one register per enabled edge; the user must
// write only when idle, as the block does not enforce it.
module affine_gap_global_alignment_score
    import agas_pkg::*;
#(
    parameter int MAX_LEN     = AGAS_MAX_LEN,
    parameter int SYMBOL_BITS = AGAS_SYMBOL_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    agas_in_if.sink    i_in,
    agas_out_if.source o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = LW + 12;
    localparam int XW = SW + AGAS_SCORE_W;

    // configuration registers
    logic signed [7:0] r_match, r_mismatch;
    logic [7:0]        r_open, r_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= 8'sd3;
            r_mismatch <= -8'sd1;
            r_open     <= 8'd5;
            r_ext      <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MATCH:    r_match    <= $signed(i_cfg_data);
                REG_MISMATCH: r_mismatch <= $signed(i_cfg_data);
                REG_OPEN:     r_open     <= i_cfg_data;
                REG_EXTEND:   r_ext      <= i_cfg_data;
                default:      r_open     <= r_open;
            endcase
        end
    end

    logic signed [SW-1:0] open_s, ext_s, oc_s;
    assign open_s = $signed({{(SW-8){1'b0}}, r_open});
    assign ext_s  = $signed({{(SW-8){1'b0}}, r_ext});
    assign oc_s   = open_s + ext_s;

    // sequencer and control registers
    t_state r_state, n_state;
    logic [LW-1:0] r_len_a, r_len_b, r_m, r_n, r_i, r_j;
    logic          r_ovf, r_drop;
    logic          in_fire;
    logic          is_load_a, is_load_b, is_run;
    logic          room_a, room_b;
    logic          last_col, last_row, both_set;

    assign in_fire   = i_in.valid && i_in.ready;
    assign is_load_a = in_fire && (i_in.action == ACT_LOAD_A);
    assign is_load_b = in_fire && (i_in.action == ACT_LOAD_B);
    assign is_run    = in_fire && (i_in.action == ACT_RUN);
    assign room_a    = r_len_a < LW'(MAX_LEN);
    assign room_b    = r_len_b < LW'(MAX_LEN);
    assign last_col  = (r_j == r_n - LW'(1));
    assign last_row  = (r_i == r_m - LW'(1));
    assign both_set  = (r_m != '0) && (r_n != '0);

    // pipeline stage between memory read and cell compute
    logic          r_v1, r_col1, r_final, r_row1;
    logic [AW-1:0] r_addr1;

    // cell datapath registers
    logic signed [SW-1:0] r_diag, r_left_m, r_left_iy, r_top, r_border, r_score;
    logic [LW+7:0]        r_prod;

    // output register
    logic                           r_out_valid, r_out_drop;
    logic signed [AGAS_SCORE_W-1:0] r_out_score;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (is_run) n_state = S_START;
            S_START: n_state = both_set ? S_ROW : S_EDGE;
            S_EDGE:  n_state = S_DONE;
            S_ROW:   n_state = S_CELL;
            S_CELL:  if (last_col) n_state = last_row ? S_DRAIN : S_ROW;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    logic          issue_cell;
    logic [AW-1:0] a_raddr;
    always_comb begin
        i_in.ready = 1'b0;
        issue_cell = 1'b0;
        case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_CELL:  issue_cell = 1'b1;
            default: issue_cell = 1'b0;
        endcase
    end
    assign a_raddr = r_i[AW-1:0];

    // memories: the two sequences and the two working rows
    logic [SYMBOL_BITS-1:0] a_q, b_q, sym_in;
    logic [SW-1:0]          best_q, vg_q;
    logic signed [SW-1:0]   up, ix, iy, m_new, dsum, s_val, ix_b, iy_b, ix_a, iy_a, mx;

    assign sym_in = i_in.symbol[SYMBOL_BITS-1:0];

    agas_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN), .AW(AW)) u_seq_a (
        .i_clk(i_clk), .i_we(is_load_a && room_a), .i_waddr(r_len_a[AW-1:0]),
        .i_wdata(sym_in), .i_raddr(a_raddr), .o_rdata(a_q)
    );
    agas_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN), .AW(AW)) u_seq_b (
        .i_clk(i_clk), .i_we(is_load_b && room_b), .i_waddr(r_len_b[AW-1:0]),
        .i_wdata(sym_in), .i_raddr(r_j[AW-1:0]), .o_rdata(b_q)
    );
    agas_ram #(.WIDTH(SW), .DEPTH(MAX_LEN), .AW(AW)) u_row_best (
        .i_clk(i_clk), .i_we(r_v1), .i_waddr(r_addr1),
        .i_wdata(m_new), .i_raddr(r_j[AW-1:0]), .o_rdata(best_q)
    );
    agas_ram #(.WIDTH(SW), .DEPTH(MAX_LEN), .AW(AW)) u_row_vgap (
        .i_clk(i_clk), .i_we(r_v1), .i_waddr(r_addr1),
        .i_wdata(ix), .i_raddr(r_j[AW-1:0]), .o_rdata(vg_q)
    );

    // cell compute: M, Ix, Iy of one cell
    always_comb begin
        up    = r_row1 ? r_top : $signed(best_q);
        ix_a  = up - oc_s;
        ix_b  = $signed(vg_q) - ext_s;
        ix    = (!r_row1 && (ix_b > ix_a)) ? ix_b : ix_a;
        iy_a  = r_left_m - oc_s;
        iy_b  = r_left_iy - ext_s;
        iy    = (!r_col1 && (iy_b > iy_a)) ? iy_b : iy_a;
        s_val = (a_q == b_q) ? SW'(r_match) : SW'(r_mismatch);
        dsum  = r_diag + s_val;
        mx    = (ix > iy) ? ix : iy;
        m_new = (dsum > mx) ? dsum : mx;
    end

    // saturate a score into the output width
    logic signed [XW-1:0] wide;
    logic signed [AGAS_SCORE_W-1:0] sat_score;
    always_comb begin
        wide = XW'(r_score);
        if (wide > XW'(8388607)) begin
            sat_score = 24'sh7FFFFF;
        end else if (wide < -XW'(8388608)) begin
            sat_score = -24'sh800000;
        end else begin
            sat_score = wide[AGAS_SCORE_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue_cell;
            if (is_load_a) begin
                if (room_a) r_len_a <= r_len_a + LW'(1);
                else r_ovf <= 1'b1;
            end
            if (is_load_b) begin
                if (room_b) r_len_b <= r_len_b + LW'(1);
                else r_ovf <= 1'b1;
            end
            if (is_run) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf   <= 1'b0;
            end
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (is_run) begin
            r_m    <= r_len_a;
            r_n    <= r_len_b;
            r_drop <= r_ovf;
        end
        case (r_state)
            S_START: begin
                r_prod   <= (r_m == '0 ? r_n : r_m) * r_ext;
                r_i      <= '0;
                r_border <= -open_s;
                r_top    <= -oc_s;
            end
            S_EDGE: begin
                r_score <= both_set ? r_score :
                    (((r_m == '0) && (r_n == '0)) ? '0 :
                    -(open_s + $signed({{(SW-LW-8){1'b0}}, r_prod})));
            end
            S_ROW: begin
                r_j <= '0;
            end
            S_CELL: begin
                r_j <= r_j + LW'(1);
                if (last_col && !last_row) r_i <= r_i + LW'(1);
            end
            default: r_j <= r_j;
        endcase
        r_addr1 <= r_j[AW-1:0];
        r_col1  <= (r_j == '0);
        r_final <= last_col && last_row;
        // row start overrides the trailing cell of the previous row
        if (r_state == S_ROW) begin
            r_row1   <= (r_i == '0);
            r_diag   <= (r_i == '0) ? '0 : r_border;
            r_left_m <= r_border - ext_s;
            r_border <= r_border - ext_s;
        end else if (r_v1) begin
            r_diag    <= up;
            r_left_m  <= m_new;
            r_left_iy <= iy;
        end
        if (r_v1) begin
            if (r_row1) r_top <= r_top - ext_s;
            if (r_final) r_score <= m_new;
        end
        if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
            r_out_score <= sat_score;
            r_out_drop  <= r_drop;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.score   = r_out_score;
    assign o_out.dropped = r_out_drop;
endmodule

// File: rtl/agas_checker.sv
// port level checks for the alignment block, bound to the top level
// depends on agas_pkg and the macro header
`include "affine_gap_global_alignment_score_defines.svh"
module agas_checker
    import agas_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [AGAS_SCORE_W-1:0] i_out_score,
    input logic                    i_out_dropped
);
    // a stalled word stays
    `AGAS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `AGAS_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_score) && $stable(i_out_dropped))
    // a new word comes only out of a busy run
    `AGAS_ASSERT(a_word_after_run, i_clk, i_rst_n, $rose(i_out_valid) |-> !$past(i_in_ready))
    // reset empties the output register
    `AGAS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind affine_gap_global_alignment_score agas_checker u_agas_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_score(o_out.score),
    .i_out_dropped(o_out.dropped)
);

// File: tb/sv/agas_score_checker.sv
// score checker for the affine gap global alignment block
// watches the input and result channels, predicts scores, counts mismatches
// depends on agas_pkg
module agas_score_checker
    import agas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_in_action,
    input  logic [7:0] i_in_symbol,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [AGAS_SCORE_W-1:0] i_out_score,
    input  logic       i_out_dropped,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending,
    output int         o_scores_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [AGAS_SCORE_W-1:0] score;
        logic                    dropped;
    } t_score_word;

    t_score_word expected_scores[$];
    byte unsigned seq_a[$];
    byte unsigned seq_b[$];
    bit           overflow;
    longint       match_val, mismatch_val, open_val, extend_val;
    longint       best_row[AGAS_MAX_LEN+1];
    longint       vgap_row[AGAS_MAX_LEN+1];

    assign o_pending = expected_scores.size();

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    // gotoh recurrence over two working rows
    function automatic longint global_score();
        int     m, n;
        longint diag, left_m, left_iy, up_m, s, ix, iy, cur_m;
        m = seq_a.size();
        n = seq_b.size();
        best_row[0] = 0;
        for (int j = 1; j <= n; j++) best_row[j] = -(open_val + j * extend_val);
        for (int i = 1; i <= m; i++) begin
            diag = best_row[0];
            left_m = -(open_val + i * extend_val);
            left_iy = 0;
            best_row[0] = left_m;
            for (int j = 1; j <= n; j++) begin
                up_m = best_row[j];
                s = (seq_a[i-1] == seq_b[j-1]) ? match_val : mismatch_val;
                ix = up_m - open_val - extend_val;
                iy = left_m - open_val - extend_val;
                if (i > 1 && vgap_row[j] - extend_val > ix) ix = vgap_row[j] - extend_val;
                if (j > 1 && left_iy - extend_val > iy) iy = left_iy - extend_val;
                cur_m = diag + s;
                if (ix > cur_m) cur_m = ix;
                if (iy > cur_m) cur_m = iy;
                diag = up_m;
                best_row[j] = cur_m;
                vgap_row[j] = ix;
                left_m = cur_m;
                left_iy = iy;
            end
        end
        return best_row[n];
    endfunction

    always @(posedge i_clk) begin
        longint      sc;
        t_score_word w;
        if (!i_rst_n) begin
            match_val = 3;
            mismatch_val = -1;
            open_val = 5;
            extend_val = 1;
            seq_a.delete();
            seq_b.delete();
            overflow = 0;
            o_errors = 0;
            o_scores_seen = 0;
            expected_scores.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MATCH:    match_val = longint'($signed(i_cfg_data));
                    REG_MISMATCH: mismatch_val = longint'($signed(i_cfg_data));
                    REG_OPEN:     open_val = i_cfg_data;
                    REG_EXTEND:   extend_val = i_cfg_data;
                    default: ;
                endcase
            end
            // accepted input word
            if (i_in_valid && i_in_ready) begin
                case (i_in_action)
                    ACT_LOAD_A: if (seq_a.size() < AGAS_MAX_LEN) seq_a = {seq_a, i_in_symbol};
                                else overflow = 1;
                    ACT_LOAD_B: if (seq_b.size() < AGAS_MAX_LEN) seq_b = {seq_b, i_in_symbol};
                                else overflow = 1;
                    ACT_RUN: begin
                        sc = global_score();
                        if (sc > 8388607) sc = 8388607;
                        if (sc < -8388608) sc = -8388608;
                        w.score = sc[AGAS_SCORE_W-1:0];
                        w.dropped = overflow;
                        expected_scores = {expected_scores, w};
                        seq_a.delete();
                        seq_b.delete();
                        overflow = 0;
                    end
                    default: ;
                endcase
            end
            // accepted result word
            if (i_out_valid && i_out_ready) begin
                o_scores_seen++;
                if (expected_scores.size() == 0) begin
                    report("result word with nothing expected");
                end else begin
                    w = expected_scores.pop_front();
                    if (i_out_score !== w.score)
                        report($sformatf("score got %0d want %0d",
                            $signed(i_out_score), $signed(w.score)));
                    if (i_out_dropped !== w.dropped)
                        report($sformatf("dropped got %b want %b", i_out_dropped, w.dropped));
                end
            end
        end
    end
endmodule

// File: tb/sv/affine_gap_global_alignment_score_tb.sv
// testbench top for the affine gap global alignment block
// drives loads, runs and register writes; the checker predicts and compares
// depends on agas_pkg, agas_if, agas_score_checker and the block
module affine_gap_global_alignment_score_tb;
    import agas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 400000;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       cfg_we = 0;
    logic [1:0] cfg_idx = REG_MATCH;
    logic [7:0] cfg_data = 0;
    int         errors, pending, scores_seen;
    longint     cycles = 0;
    int         sent = 0;
    int         runs = 0;

    agas_in_if  in_ch ();
    agas_out_if out_ch ();

    initial begin
        in_ch.valid = 0;
        in_ch.action = ACT_LOAD_A;
        in_ch.symbol = 0;
        out_ch.ready = 0;
    end

    always #2 i_clk = ~i_clk;

    affine_gap_global_alignment_score u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    agas_score_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready),
        .i_in_action(in_ch.action), .i_in_symbol(in_ch.symbol),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_out_score(out_ch.score), .i_out_dropped(out_ch.dropped),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_scores_seen(scores_seen)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver stalls: gap drawn per word, some stretches with none
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                out_ch.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            @(posedge i_clk iff out_ch.valid);
        end
    end

    // one input word, with a drawn idle gap in front
    task automatic send_word(input logic [1:0] act, input logic [7:0] sym, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.action <= act;
        in_ch.symbol <= sym;
        @(posedge i_clk iff in_ch.ready);
        sent++;
        if (act == ACT_RUN) runs++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    // wait for all scores, then let the sequencer settle before writes
    task automatic write_regs(input logic [7:0] ms, input logic [7:0] mm,
                              input logic [7:0] op, input logic [7:0] ex);
        logic [7:0] vals[4];
        go_idle();
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        vals = '{ms, mm, op, ex};
        for (int r = 0; r < 4; r++) begin
            cfg_we <= 1;
            cfg_idx <= r[1:0];
            cfg_data <= vals[r];
            @(posedge i_clk);
        end
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // load two random sequences and run
    task automatic random_pair(input int len_a, input int len_b, input int alpha, input bit burst);
        int la, lb;
        la = 0;
        lb = 0;
        while (la < len_a || lb < len_b) begin
            if (lb >= len_b || (la < len_a && $urandom_range(0, 1))) begin
                send_word(ACT_LOAD_A, 8'($urandom_range(0, alpha)), burst);
                la++;
            end else begin
                send_word(ACT_LOAD_B, 8'($urandom_range(0, alpha)), burst);
                lb++;
            end
        end
        send_word(ACT_RUN, 8'($urandom), burst);
    endtask

    initial begin
        bit burst;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty, one side empty, extremes of symbols, ignored action
        send_word(ACT_RUN, 8'hff, 1);
        send_word(ACT_LOAD_A, 8'h00, 0);
        send_word(ACT_RUN, 8'h00, 0);
        send_word(ACT_LOAD_B, 8'hff, 0);
        send_word(ACT_LOAD_B, 8'h80, 0);
        send_word(ACT_RUN, 8'h55, 0);
        send_word(ACT_LOAD_A, 8'hff, 0);
        send_word(2'd3, 8'haa, 0);
        send_word(ACT_LOAD_B, 8'hff, 0);
        send_word(ACT_RUN, 8'h00, 0);
        send_word(ACT_LOAD_A, 8'h7f, 1);
        send_word(ACT_LOAD_A, 8'h01, 1);
        send_word(ACT_LOAD_B, 8'h01, 1);
        send_word(ACT_RUN, 8'h00, 1);

        // random phases over several register settings, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_regs(8'sd3, -8'sd1, 8'd5, 8'd1);
                1: write_regs(8'h7f, 8'h80, 8'hff, 8'hff);
                2: write_regs(8'h80, 8'h7f, 8'h00, 8'h00);
                3: write_regs(8'h00, 8'h00, 8'hff, 8'h00);
                4: write_regs(8'h7f, 8'h7f, 8'h00, 8'hff);
                default: write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            for (int t = 0; t < 10; t++) begin
                burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    send_word(2'd3, 8'($urandom), burst);
                random_pair($urandom_range(0, 8), $urandom_range(0, 8),
                            ($urandom_range(0, 1) ? 3 : 255), burst);
            end
        end
        // a few longer sequences
        write_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        for (int t = 0; t < 3; t++)
            random_pair($urandom_range(20, 40), $urandom_range(20, 40), 3, 0);

        go_idle();
        wait (pending == 0);
        repeat (50) @(posedge i_clk);
        $display("sent %0d input words, %0d runs, %0d score words checked",
                 sent, runs, scores_seen);
        $display("covered empty sequences, ignored actions and extreme score settings");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/agas_pkg.sv
rtl/agas_if.sv
rtl/agas_ram.sv
rtl/affine_gap_global_alignment_score.sv
rtl/agas_checker.sv
tb/sv/agas_score_checker.sv
tb/sv/affine_gap_global_alignment_score_tb.sv
